FILE: rtl/tdb_pkg.sv
package tdb_pkg;

  localparam int SampleW = 8;
  localparam int StateW  = 2;
  localparam int MultW   = 4;
  localparam int CfgIdxW = 2;
  localparam int CfgDatW = 4;

  localparam logic [StateW-1:0] ST_NOT_INSTALLED = 2'd0;
  localparam logic [StateW-1:0] ST_DEAD          = 2'd1;
  localparam logic [StateW-1:0] ST_TOUCHED       = 2'd2;
  localparam logic [StateW-1:0] ST_RELEASED      = 2'd3;

  localparam logic [SampleW-1:0] FAIL_CODE = 8'd254;

  localparam logic [CfgIdxW-1:0] REG_INSTALLED = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_TOUCH_MUL = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_REL_MUL   = 2'd2;

  localparam logic [MultW-1:0] TOUCH_MUL_RST = 4'd10;
  localparam logic [MultW-1:0] REL_MUL_RST   = 4'd5;

  typedef struct packed {
    logic [StateW-1:0]  channel_state;
    logic [SampleW-1:0] baseline_average;
  } result_t;

endpackage

FILE: rtl/touch_detector_with_baseline_unit.sv
// channel   | dir | handshake                    | word
// ----------+-----+------------------------------+--------------------------------------
// sample    | in  | in_valid_i / in_ready_o      | sample_i
// result    | out | out_valid_o / out_ready_i    | channel_state_o, baseline_average_o
// config    | in  | cfg_valid_i / cfg_ready_o    | cfg_index_i, cfg_data_i
//
// one sample per cycle unless the skid word is full; each result is registered
// the window lives in a memory with a registered read of the next oldest slot,
// so the sum update and the new average fit into the accepting cycle
// the average is registered and found by a reciprocal multiply of the new sum
// reset clears per-slot valid bits at once; no clearing pass is needed
// a two-word output buffer keeps the input open for one stalled result
module touch_detector_with_baseline_unit
  import tdb_pkg::*;
#(
  parameter int WINDOW_DEPTH = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [SampleW-1:0]  sample_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [StateW-1:0]   channel_state_o,
  output logic [SampleW-1:0]  baseline_average_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDatW-1:0]  cfg_data_i
);

  localparam int PtrW    = $clog2(WINDOW_DEPTH);
  localparam int SumW    = SampleW + PtrW;
  localparam int RecipK  = SumW + PtrW;
  localparam int RecipW  = SumW + 1;
  localparam int ProdW   = SumW + RecipW;
  localparam int ThrW    = SampleW + MultW;
  localparam logic [RecipW-1:0] RecipM =
    RecipW'((2 ** RecipK + WINDOW_DEPTH - 1) / WINDOW_DEPTH);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(WINDOW_DEPTH - 1);

  logic [SampleW-1:0] win_mem [WINDOW_DEPTH];
  logic [SampleW-1:0] rd_q;
  logic [WINDOW_DEPTH-1:0] vld_q;
  logic [PtrW-1:0] ptr_q, ptr_d;
  logic [SumW-1:0] sum_q, sum_d, sum_push;
  logic [SampleW-1:0] avg_q, avg_d, avg_push;
  logic [ProdW-1:0] recip_prod;
  logic [StateW-1:0] st_q, st_d, st_next;
  logic installed_q;
  logic [MultW-1:0] tmul_q, rmul_q;

  logic in_fire, out_fire, cfg_fire, push, active;
  logic [SampleW-1:0] old_val;
  logic [ThrW-1:0] thr_touch, thr_rel;

  result_t res, out_q, skid_q;
  logic out_vld_q, skid_full_q;

  assign in_ready_o  = !skid_full_q;
  assign cfg_ready_o = 1'b1;
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_fire    = out_vld_q && out_ready_i;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;

  // oldest slot was prefetched last cycle; unwritten slots read as zero
  assign old_val = vld_q[ptr_q] ? rd_q : '0;

  assign thr_touch = ThrW'(avg_q) * ThrW'(tmul_q);
  assign thr_rel   = ThrW'(avg_q) * ThrW'(rmul_q);
  assign active    = (st_q == ST_RELEASED) || (st_q == ST_TOUCHED);

  always_comb begin
    st_next = st_q;
    push    = 1'b0;
    if (active) begin
      if (sample_i == FAIL_CODE) begin
        st_next = ST_DEAD;
      end else begin
        if (st_q == ST_RELEASED && ThrW'(sample_i) > thr_touch) begin
          st_next = ST_TOUCHED;
        end else if (st_q == ST_TOUCHED && ThrW'(sample_i) < thr_rel) begin
          st_next = ST_RELEASED;
        end
        push = (st_next == ST_RELEASED);
      end
    end
  end

  // candidate sum and average if this sample enters the window
  assign sum_push   = sum_q - SumW'(old_val) + SumW'(sample_i);
  assign recip_prod = ProdW'(sum_push) * ProdW'(RecipM);
  assign avg_push   = (recip_prod[RecipK +: SampleW] == '0) ? SampleW'(1)
                                                            : recip_prod[RecipK +: SampleW];

  always_comb begin
    sum_d = sum_q;
    avg_d = avg_q;
    ptr_d = ptr_q;
    st_d  = st_q;
    if (cfg_fire && cfg_index_i == REG_INSTALLED) begin
      st_d = cfg_data_i[0] ? ST_RELEASED : ST_NOT_INSTALLED;
    end else if (in_fire) begin
      st_d = st_next;
    end
    if (in_fire && push) begin
      sum_d = sum_push;
      avg_d = avg_push;
      ptr_d = (ptr_q == LastPtr) ? '0 : ptr_q + PtrW'(1);
    end
  end

  assign res.channel_state    = in_fire ? st_next : st_q;
  assign res.baseline_average = avg_q;

  always_ff @(posedge clk_i) begin
    if (in_fire && push) begin
      win_mem[ptr_q] <= sample_i;
    end
    rd_q <= win_mem[ptr_d];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      ptr_q       <= '0;
      sum_q       <= '0;
      avg_q       <= SampleW'(1);
      st_q        <= ST_RELEASED;
      installed_q <= 1'b1;
      tmul_q      <= TOUCH_MUL_RST;
      rmul_q      <= REL_MUL_RST;
    end else begin
      if (in_fire && push) begin
        vld_q[ptr_q] <= 1'b1;
      end
      ptr_q <= ptr_d;
      sum_q <= sum_d;
      avg_q <= avg_d;
      st_q  <= st_d;
      if (cfg_fire) begin
        unique case (cfg_index_i)
          REG_INSTALLED: installed_q <= cfg_data_i[0];
          REG_TOUCH_MUL: tmul_q      <= cfg_data_i;
          REG_REL_MUL:   rmul_q      <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // output register plus one skid word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q   <= 1'b0;
      skid_full_q <= 1'b0;
    end else begin
      if (!out_vld_q || out_fire) begin
        if (skid_full_q) begin
          out_vld_q   <= 1'b1;
          skid_full_q <= 1'b0;
        end else begin
          out_vld_q <= in_fire;
        end
      end else if (in_fire) begin
        skid_full_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_vld_q || out_fire) begin
      out_q <= skid_full_q ? skid_q : res;
    end
    if (out_vld_q && !out_fire && in_fire) begin
      skid_q <= res;
    end
  end

  assign out_valid_o        = out_vld_q;
  assign channel_state_o    = out_q.channel_state;
  assign baseline_average_o = out_q.baseline_average;

  a_ready_low_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_vld_q)
    else $error("input stalled with empty output register");

  a_avg_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    avg_q != '0)
    else $error("baseline average reached zero");

  a_dead_sticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_DEAD && !(cfg_fire && cfg_index_i == REG_INSTALLED)) |=> st_q == ST_DEAD)
    else $error("dead channel left dead state");

  a_push_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && push) |-> (active && sample_i != FAIL_CODE && installed_q))
    else $error("window written on inactive channel");

endmodule

FILE: tb/sv/touch_channel_checker.sv
`timescale 1ns / 100ps
module touch_channel_checker
  import tdb_pkg::*;
#(
  parameter int WINDOW_DEPTH = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic [SampleW-1:0] sample_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic [StateW-1:0]  channel_state_i,
  input  logic [SampleW-1:0] baseline_average_i,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CfgDatW-1:0] cfg_data_i,
  output int                 fail_count_o,
  output int                 pending_o,
  output int                 accepts_o
);

  localparam int SumW = SampleW + $clog2(WINDOW_DEPTH);
  localparam int MaxReports = 100;

  logic               installed;
  logic [MultW-1:0]   touch_mul;
  logic [MultW-1:0]   rel_mul;
  logic [StateW-1:0]  chan_state;
  logic [SampleW-1:0] window [WINDOW_DEPTH];
  logic [SumW-1:0]    window_sum;
  int                 oldest;
  int                 result_idx;
  result_t            expected_results[$];
  result_t            want;

  task automatic report_mismatch(input string what, input int got, input int want_v);
    if (fail_count_o < MaxReports) begin
      $display("%0t result %0d: %s got %0d expected %0d", $time, result_idx, what, got,
               want_v);
    end
    fail_count_o++;
  endtask

  function automatic logic [SampleW-1:0] baseline_of(input logic [SumW-1:0] sum);
    logic [SumW-1:0] avg;
    avg = SumW'(sum / WINDOW_DEPTH);
    return (avg == '0) ? SampleW'(1) : avg[SampleW-1:0];
  endfunction

  function automatic void predict_channel(input logic [SampleW-1:0] s);
    result_t            res;
    logic [SampleW-1:0] avg;
    int                 touch_lim;
    int                 rel_lim;
    avg       = baseline_of(window_sum);
    touch_lim = int'(avg) * int'(touch_mul);
    rel_lim   = int'(avg) * int'(rel_mul);
    if (chan_state == ST_RELEASED || chan_state == ST_TOUCHED) begin
      if (s == FAIL_CODE) begin
        chan_state = ST_DEAD;
      end else begin
        if (chan_state == ST_RELEASED && int'(s) > touch_lim) begin
          chan_state = ST_TOUCHED;
        end else if (chan_state == ST_TOUCHED && int'(s) < rel_lim) begin
          chan_state = ST_RELEASED;
        end
        if (chan_state == ST_RELEASED) begin
          window_sum     = window_sum - window[oldest] + s;
          window[oldest] = s;
          oldest         = (oldest + 1) % WINDOW_DEPTH;
        end
      end
    end
    res.channel_state    = chan_state;
    res.baseline_average = avg;
    expected_results.push_back(res);
  endfunction

  function automatic void apply_config(input logic [CfgIdxW-1:0] idx,
                                       input logic [CfgDatW-1:0] data);
    case (idx)
      REG_INSTALLED: begin
        installed  = data[0];
        chan_state = installed ? ST_RELEASED : ST_NOT_INSTALLED;
      end
      REG_TOUCH_MUL: begin
        touch_mul = data[MultW-1:0];
      end
      REG_REL_MUL: begin
        rel_mul = data[MultW-1:0];
      end
      default: begin
      end
    endcase
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      installed  = 1'b1;
      touch_mul  = TOUCH_MUL_RST;
      rel_mul    = REL_MUL_RST;
      chan_state = ST_RELEASED;
      foreach (window[i]) window[i] = '0;
      window_sum = '0;
      oldest     = 0;
      result_idx = 0;
      expected_results.delete();
      pending_o  = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result with nothing pending, channel_state", channel_state_i, -1);
        end else begin
          want = expected_results.pop_front();
          if (channel_state_i !== want.channel_state) begin
            report_mismatch("channel_state", channel_state_i, want.channel_state);
          end
          if (baseline_average_i !== want.baseline_average) begin
            report_mismatch("baseline_average", baseline_average_i, want.baseline_average);
          end
        end
        result_idx++;
        accepts_o++;
      end
      if (cfg_valid_i && cfg_ready_i) begin
        apply_config(cfg_index_i, cfg_data_i);
        accepts_o++;
      end
      if (in_valid_i && in_ready_i) begin
        predict_channel(sample_i);
        accepts_o++;
      end
      pending_o = expected_results.size();
    end
  end

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 100ps
module tb_top;
  import tdb_pkg::*;

  localparam int WINDOW_DEPTH = 8;
  localparam int IDLE_LIMIT   = 2000;
  localparam int HOLD_CYCLES  = 400;
  localparam int PHASES       = 12;
  localparam int PHASE_ITEMS  = 150;
  localparam int HOLD_PHASE   = 5;

  localparam logic [CfgIdxW-1:0] REG_UNUSED = 2'd3;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [SampleW-1:0] sample_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic [StateW-1:0]  channel_state_o;
  logic [SampleW-1:0] baseline_average_o;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [CfgDatW-1:0] cfg_data_i;

  int fail_count;
  int pending;
  int accepts;
  bit calm;
  bit hold_req;
  int level;

  touch_detector_with_baseline_unit #(
    .WINDOW_DEPTH(WINDOW_DEPTH)
  ) dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .sample_i          (sample_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .channel_state_o   (channel_state_o),
    .baseline_average_o(baseline_average_o),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i)
  );

  touch_channel_checker #(
    .WINDOW_DEPTH(WINDOW_DEPTH)
  ) checker_i (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_i        (in_ready_o),
    .sample_i          (sample_i),
    .out_valid_i       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .channel_state_i   (channel_state_o),
    .baseline_average_i(baseline_average_o),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_i       (cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .fail_count_o      (fail_count),
    .pending_o         (pending),
    .accepts_o         (accepts)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    else if (r < 88) return $urandom_range(1, 3);
    else if (r < 97) return $urandom_range(4, 12);
    else return $urandom_range(20, 60);
  endfunction

  function automatic logic [SampleW-1:0] random_sample();
    int r;
    int v;
    r = $urandom_range(0, 199);
    if (r < 10) level = $urandom_range(0, 255);
    if (r < 100) begin
      v = level + $urandom_range(0, 16) - 8;
      if (v < 0) v = 0;
      if (v > 255) v = 255;
    end else if (r < 130) begin
      v = $urandom_range(0, 255);
    end else if (r < 160) begin
      v = $urandom_range(0, 15);
    end else if (r < 199) begin
      v = $urandom_range(128, 255);
    end else begin
      v = FAIL_CODE;
    end
    return SampleW'(v);
  endfunction

  task automatic send_sample(input logic [SampleW-1:0] s);
    int gap;
    gap = calm ? 0 : pick_gap();
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_i   <= s;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDatW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // receiver: random stalls, plus one long hold to back up the input
  initial begin : receiver
    int stall;
    int hold;
    bit held;
    stall = 0;
    hold  = 0;
    held  = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req && !held) begin
        hold = HOLD_CYCLES;
        held = 1'b1;
      end
      if (hold > 0) begin
        out_ready_i <= 1'b0;
        hold--;
      end else if (stall > 0) begin
        out_ready_i <= 1'b0;
        stall--;
      end else begin
        out_ready_i <= 1'b1;
        if (!calm) stall = pick_gap();
      end
    end
  end

  initial begin : watchdog
    int idle;
    int seen;
    idle = 0;
    seen = 0;
    while (idle < IDLE_LIMIT) begin
      @(negedge clk_i);
      if (accepts != seen) begin
        seen = accepts;
        idle = 0;
      end else begin
        idle++;
      end
    end
    $display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
    $display("TEST FAILED");
    $finish;
  end

  initial begin : stimulus
    logic [SampleW-1:0] directed[$];
    logic [CfgDatW-1:0] d;
    in_valid_i  = 1'b0;
    sample_i    = '0;
    out_ready_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = REG_INSTALLED;
    cfg_data_i  = '0;
    calm        = 1'b0;
    hold_req    = 1'b0;
    level       = 0;
    rst_ni      = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // default thresholds: touch, release, failure, ignored while dead
    directed = '{8'd0, 8'd255, 8'd3, 8'd10, 8'd11, 8'd5, 8'd4, FAIL_CODE, 8'd0, 8'd255};
    foreach (directed[i]) send_sample(directed[i]);
    drain();
    write_reg(REG_INSTALLED, 4'h1);
    send_sample(8'd7);
    drain();
    write_reg(REG_INSTALLED, 4'hE);
    send_sample(FAIL_CODE);
    send_sample(8'd200);
    drain();
    // zero multipliers
    write_reg(REG_INSTALLED, 4'h3);
    write_reg(REG_TOUCH_MUL, 4'd0);
    send_sample(8'd0);
    send_sample(8'd1);
    drain();
    write_reg(REG_REL_MUL, 4'd0);
    send_sample(8'd0);
    drain();
    write_reg(REG_TOUCH_MUL, 4'd15);
    write_reg(REG_REL_MUL, 4'd15);
    write_reg(REG_UNUSED, 4'hA);
    send_sample(8'd20);
    send_sample(8'd128);
    drain();
    write_reg(REG_TOUCH_MUL, 4'd1);
    write_reg(REG_REL_MUL, 4'd1);
    send_sample(8'd2);
    send_sample(8'd1);
    drain();

    for (int p = 0; p < PHASES; p++) begin
      d    = CfgDatW'($urandom());
      d[0] = ($urandom_range(0, 7) != 0);
      if ($urandom_range(0, 3) == 0) write_reg(REG_UNUSED, CfgDatW'($urandom()));
      write_reg(REG_TOUCH_MUL, CfgDatW'($urandom_range(0, 15)));
      write_reg(REG_REL_MUL, CfgDatW'($urandom_range(0, 15)));
      write_reg(REG_INSTALLED, d);
      calm  = (p % 4 == 3) || (p == HOLD_PHASE);
      level = $urandom_range(0, 255);
      if (p == HOLD_PHASE) hold_req = 1'b1;
      for (int i = 0; i < PHASE_ITEMS; i++) send_sample(random_sample());
      drain();
    end

    repeat (8) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
